// File: rtl/core/ntw_pkg.sv
// ----------------------------------------------------------------------------
// ntw_pkg: shared types and constants of the number-to-word token block
// token codes, command codes, queue entry layout and sequencer states
// ----------------------------------------------------------------------------
package ntw_pkg;

  localparam int unsigned ValueW    = 30;
  localparam int unsigned WordW     = 5;
  localparam int unsigned DigitW    = 4;
  localparam int unsigned NumDigits = 9;
  localparam int unsigned BcdW      = NumDigits * DigitW;
  localparam int unsigned ConvBits  = 3;
  localparam int unsigned ConvSteps = ValueW / ConvBits;
  localparam int unsigned CntW      = $clog2(ConvSteps);
  localparam int unsigned NumSlots  = 14;
  localparam int unsigned QDepth    = 2;
  localparam int unsigned QPtrW     = $clog2(QDepth);
  localparam int unsigned QCntW     = $clog2(QDepth + 1);

  localparam logic [ValueW-1:0] NumMax    = ValueW'(999999999);
  localparam logic [6:0]        TwoDigMax = 7'd99;
  localparam logic [6:0]        HourFold  = 7'd12;
  localparam logic [6:0]        HourMin   = 7'd13;

  typedef logic [WordW-1:0] word_t;

  localparam word_t TokZero     = 5'd0;
  localparam word_t TokTen      = 5'd10;
  localparam word_t TokTwenty   = 5'd20;
  localparam word_t TokHundred  = 5'd28;
  localparam word_t TokThousand = 5'd29;
  localparam word_t TokMillion  = 5'd30;

  typedef enum logic [1:0] {
    CMD_NUMBER  = 2'd0,
    CMD_HOURS   = 2'd1,
    CMD_MINUTES = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_CONV,
    FS_PUSH
  } front_state_e;

  // one queued run: token per slot and which slots are spoken
  typedef struct packed {
    logic [NumSlots-1:0]             mask;
    logic [NumSlots-1:0][WordW-1:0]  tok;
  } entry_t;

  // queue status seen by producer and consumer
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// File: rtl/core/ntw_intf.sv
// ----------------------------------------------------------------------------
// ntw_intf: request and token channel interfaces
// valid/ready channels carrying the command request and the word tokens
// ----------------------------------------------------------------------------
interface ntw_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [29:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

interface ntw_tok_if;
  logic       valid;
  logic       ready;
  logic [4:0] word;
  logic       last;

  modport source (output valid, output word, output last, input ready);
  modport sink   (input valid, input word, input last, output ready);
endinterface

// File: rtl/core/ntw_front.sv
// ----------------------------------------------------------------------------
// ntw_front: request intake, decimal conversion and token planning
// clamps and folds the value, converts it to bcd three bits a cycle and
// pushes a per-slot token plan into the queue
// ----------------------------------------------------------------------------
module ntw_front
  import ntw_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       twelve_hour_i,
  ntw_req_if.sink    req_i,
  input  q_stat_t    q_stat_i,
  output logic       push_o,
  output entry_t     entry_o
);

  front_state_e state_q, state_d;
  logic [CntW-1:0]   cnt_q;
  logic [ValueW-1:0] bin_q, bin_d;
  logic [BcdW-1:0]   bcd_q, bcd_d;
  logic [1:0]        cmd_q;
  logic              accept;
  logic              start;
  logic [ValueW-1:0] load_val;
  logic [6:0]        two_val;

  assign accept = req_i.valid && req_i.ready;
  assign start  = accept && (req_i.command != CMD_NONE);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      FS_IDLE: begin
        if (start) state_d = FS_CONV;
      end
      FS_CONV: begin
        if (cnt_q == CntW'(ConvSteps - 1)) state_d = FS_PUSH;
      end
      FS_PUSH: begin
        if (!q_stat_i.full) state_d = start ? FS_CONV : FS_IDLE;
      end
      default: state_d = FS_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    req_i.ready = 1'b0;
    push_o      = 1'b0;
    case (state_q)
      FS_IDLE: req_i.ready = 1'b1;
      FS_CONV: req_i.ready = 1'b0;
      FS_PUSH: begin
        push_o      = !q_stat_i.full;
        req_i.ready = !q_stat_i.full;
      end
      default: req_i.ready = 1'b0;
    endcase
  end

  // clamp and twelve-hour fold on the way in
  always_comb begin
    two_val = (req_i.value > ValueW'(TwoDigMax)) ? TwoDigMax : req_i.value[6:0];
    if (req_i.command == CMD_HOURS && twelve_hour_i && two_val >= HourMin) begin
      two_val = two_val - HourFold;
    end
    if (req_i.command == CMD_NUMBER) begin
      load_val = (req_i.value > NumMax) ? NumMax : req_i.value;
    end else begin
      load_val = ValueW'(two_val);
    end
  end

  // double dabble, three bits per cycle
  always_comb begin
    logic [BcdW-1:0]   b;
    logic [ValueW-1:0] x;
    b = bcd_q;
    x = bin_q;
    for (int s = 0; s < ConvBits; s++) begin
      for (int k = 0; k < NumDigits; k++) begin
        if (b[k*DigitW +: DigitW] >= 4'd5) begin
          b[k*DigitW +: DigitW] = b[k*DigitW +: DigitW] + 4'd3;
        end
      end
      b = {b[BcdW-2:0], x[ValueW-1]};
      x = {x[ValueW-2:0], 1'b0};
    end
    bcd_d = b;
    bin_d = x;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FS_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (start) begin
        cnt_q <= '0;
      end else if (state_q == FS_CONV) begin
        cnt_q <= cnt_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      bin_q <= load_val;
      bcd_q <= '0;
      cmd_q <= req_i.command;
    end else if (state_q == FS_CONV) begin
      bin_q <= bin_d;
      bcd_q <= bcd_d;
    end
  end

  // slot plan per group: hundreds digit, hundred, tens word, units digit, and a scale word for the two upper groups
  always_comb begin
    logic [DigitW-1:0] h, t, u;
    logic              nz;
    int unsigned       base;
    entry_o = '0;
    for (int g = 0; g < 3; g++) begin
      h    = bcd_q[(3*g+2)*DigitW +: DigitW];
      t    = bcd_q[(3*g+1)*DigitW +: DigitW];
      u    = bcd_q[(3*g)*DigitW +: DigitW];
      nz   = (h != '0) || (t != '0) || (u != '0);
      base = (2 - g) * 5;
      entry_o.tok[base]      = WordW'(h);
      entry_o.mask[base]     = (h != '0);
      entry_o.tok[base+1]    = TokHundred;
      entry_o.mask[base+1]   = (h != '0);
      entry_o.tok[base+2]    = (t == 4'd1) ? (TokTen + WordW'(u))
                                           : (TokTwenty + WordW'(t) - WordW'(2));
      entry_o.mask[base+2]   = (t != '0);
      entry_o.tok[base+3]    = WordW'(u);
      entry_o.mask[base+3]   = (t != 4'd1) && (u != '0);
      if (g != 0) begin
        entry_o.tok[base+4]  = (g == 2) ? TokMillion : TokThousand;
        entry_o.mask[base+4] = nz;
      end
    end
    // whole value zero: a lone zero token
    if (bcd_q == '0) begin
      entry_o.tok[13]  = TokZero;
      entry_o.mask[13] = 1'b1;
    end
    // lone minute digit gets a leading zero in the tens slot
    if (cmd_q == CMD_MINUTES && bcd_q[7:4] == '0 && bcd_q[3:0] != '0) begin
      entry_o.tok[12]  = TokZero;
      entry_o.mask[12] = 1'b1;
    end
  end

  a_push_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> (entry_o.mask != '0))
    else $error("front pushed an empty token plan");

  a_conv_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FS_CONV) |-> (cnt_q < CntW'(ConvSteps)))
    else $error("conversion step count out of range");

endmodule

// File: rtl/core/ntw_queue.sv
// ----------------------------------------------------------------------------
// ntw_queue: short plan queue between front and back
// two-entry fifo of token plans
// ----------------------------------------------------------------------------
module ntw_queue
  import ntw_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  entry_t  entry_i,
  input  logic    pop_i,
  output entry_t  head_o,
  output q_stat_t stat_o
);

  entry_t           mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;

  assign stat_o.full  = (cnt_q == QCntW'(QDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign head_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + QCntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - QCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= entry_i;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !stat_o.full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !stat_o.empty)
    else $error("pop from empty queue");

endmodule

// File: rtl/core/ntw_back.sv
// ----------------------------------------------------------------------------
// ntw_back: token sequencer
// walks the head plan slot by slot into a registered token output
// ----------------------------------------------------------------------------
module ntw_back
  import ntw_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  entry_t     head_i,
  input  q_stat_t    q_stat_i,
  output logic       pop_o,
  ntw_tok_if.source  tok_o
);

  logic [NumSlots-1:0] done_q;
  logic [NumSlots-1:0] rem, pick;
  word_t               pick_word;
  logic                pick_last;
  logic                fire;
  logic                valid_q;
  word_t               word_q;
  logic                last_q;

  assign rem       = head_i.mask & ~done_q;
  assign pick      = rem & (~rem + NumSlots'(1));
  assign pick_last = ((rem & ~pick) == '0);
  assign fire      = !q_stat_i.empty && (!valid_q || tok_o.ready);
  assign pop_o     = fire && pick_last;

  always_comb begin
    pick_word = '0;
    for (int i = 0; i < NumSlots; i++) begin
      pick_word = pick_word | (head_i.tok[i] & {WordW{pick[i]}});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      done_q  <= '0;
    end else begin
      if (fire) begin
        valid_q <= 1'b1;
        done_q  <= pick_last ? '0 : (done_q | pick);
      end else if (tok_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      word_q <= pick_word;
      last_q <= pick_last;
    end
  end

  assign tok_o.valid = valid_q;
  assign tok_o.word  = word_q;
  assign tok_o.last  = last_q;

  a_fire_has_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |-> (rem != '0))
    else $error("sequencer fired with no slot left");

  a_pop_marks_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (valid_q && last_q && done_q == '0))
    else $error("run end not flagged on the token output");

endmodule

// File: rtl/core/number_to_word_tokens.sv
// ----------------------------------------------------------------------------
// number_to_word_tokens: binary value to spoken-word token runs
// first token path: bcd conversion steps, queue push, output register
// intake: a new request is taken only after the previous conversion ends,
//   limited by the 3-bit-per-cycle bcd converter; tokens leave one per cycle
//   while a plan is queued and the output is ready, up to 14 per request
// reset: 24-hour mode, queue empty, no token pending
// ----------------------------------------------------------------------------
module number_to_word_tokens
  import ntw_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  ntw_req_if.sink   req_i,
  ntw_tok_if.source tok_o
);

  // twelve-hour fold enable, to be written only while idle; the block itself does not enforce this
  logic    twelve_hour_q;

  // front to queue
  logic    push;
  entry_t  entry;

  // queue to back
  logic    pop;
  entry_t  head;
  q_stat_t q_stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      twelve_hour_q <= 1'b0;
    end else if (cfg_we_i) begin
      twelve_hour_q <= cfg_wdata_i;
    end
  end

  // front: clamp, fold, bcd convert, plan token slots
  ntw_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .twelve_hour_i (twelve_hour_q),
    .req_i         (req_i),
    .q_stat_i      (q_stat),
    .push_o        (push),
    .entry_o       (entry)
  );

  // two plans deep so conversion overlaps token output
  ntw_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .head_o  (head),
    .stat_o  (q_stat)
  );

  // back: one token per cycle from the head plan while the token output is ready
  ntw_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head),
    .q_stat_i (q_stat),
    .pop_o    (pop),
    .tok_o    (tok_o)
  );

endmodule
